/* sv/ricker_population_step_assert.svh */
// Assertion macros shared by the Ricker population step RTL.
// Included by files that check their pipeline; no other dependencies.
`ifndef RICKER_POPULATION_STEP_ASSERT_SVH
`define RICKER_POPULATION_STEP_ASSERT_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define RPS_ASSERT_NOW(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define RPS_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

/* sv/rps_pkg.sv */
// Package for the Ricker population step: payload types, stage records,
// fixed-point constants and register indexes. No dependencies.
`timescale 1ns / 1ps

package rps_pkg;

  // Fraction bits of abundance and capacity; only the capacity reset uses it.
  localparam int FRAC_BITS = 16;
  localparam logic [31:0] SHARED_CAP_RESET = 32'(100 << FRAC_BITS);

  // Q.30 constants of the exponential.
  localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
  localparam logic [36:0] LN2_Q30  = 37'd744261118;
  localparam logic [36:0] LN2_X64  = 37'(64'd744261118 * 64'd64);
  localparam logic [48:0] RATIO_CAP = 49'h1_0000_0000_0000;
  localparam logic [51:0] TINY_MAG  = 52'h8_0000_0000;

  // Step counts of the iterative parts.
  localparam int DIV_BITS     = 49;
  localparam int KQ_BITS      = 7;
  localparam int TAYLOR_TERMS = 12;

  // floor(2^32 / i) for the Taylor divisors.
  localparam logic [32:0] RECIP [1:TAYLOR_TERMS] = '{
    33'd4294967296, 33'd2147483648, 33'd1431655765, 33'd1073741824,
    33'd858993459,  33'd715827882,  33'd613566756,  33'd536870912,
    33'd477218588,  33'd429496729,  33'd390451572,  33'd357913941
  };

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_USE_SHARED      = 2'd0,
    REG_SHARED_RATE     = 2'd1,
    REG_SHARED_CAPACITY = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0]        abundance;
    logic signed [15:0] rate;
    logic signed [31:0] capacity;
  } item_t;

  typedef struct packed {
    logic [31:0] next_abundance;
    logic        saturated;
  } result_t;

  // One step of the abundance-over-capacity divider.
  typedef struct packed {
    logic [31:0]        n;
    logic signed [15:0] r;
    logic [31:0]        k;
    logic [31:0]        rem;
    logic [DIV_BITS-1:0] q;
    logic               ovf;
    logic               neg;
    logic               zero;
  } div_t;

  // One step of the split of the exponent into multiples of ln 2.
  typedef struct packed {
    logic [31:0]        n;
    logic [36:0]        rem;
    logic [KQ_BITS-1:0] kq;
    logic               zero;
  } kq_t;

  // One step of the Taylor series of exp(f).
  typedef struct packed {
    logic [31:0]        n;
    logic [KQ_BITS-1:0] kq;
    logic [29:0]        rr;
    logic [30:0]        term;
    logic [31:0]        sum;
    logic [30:0]        p;
    logic [30:0]        q0;
    logic               zero;
  } tay_t;

endpackage

/* sv/ricker_population_step.sv */
// Ricker population step: N * exp(r * (1 - N/K)) in fixed point, pipelined.
// Depends on rps_pkg and ricker_population_step_assert.svh.
`timescale 1ns / 1ps
`include "ricker_population_step_assert.svh"

// Usage:
// A request on the item channel carries one cell's abundance, rate and
// capacity; it is taken at a clock edge with item_valid high and item_stall
// low. Each request yields exactly one request on the result channel, in
// order, carrying the next abundance and the saturation flag.
// Throughput is one item per cycle while no stall holds the pipeline. The
// pipeline has 98 register stages: one input stage, 49 divider steps for
// N/K (one quotient bit each), three stages forming the exponent, seven steps
// splitting it by ln 2, three stages per Taylor term over twelve terms, a
// multiply stage and the output register.
// The whole pipeline moves together: when result_valid is high and the
// receiver holds result_stall, every stage holds and item_stall is raised,
// so nothing is lost or repeated. Bubbles move through like items.
// The configuration port writes use_shared, shared_rate and shared_capacity
// by index at any edge with cfg_we high; writes are meant for an idle block.
// Reset (rst, synchronous) empties the pipeline and restores the registers:
// use_shared 0, shared_rate 0, shared_capacity 100.0.
module ricker_population_step import rps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int ST_KQ0     = 1 + DIV_BITS + 2;
  localparam int ST_KQ_LAST = ST_KQ0 + KQ_BITS;
  localparam int TAY_STEPS  = 3 * TAYLOR_TERMS;
  localparam int ST_TAY_END = ST_KQ_LAST + TAY_STEPS;
  localparam int NST        = ST_TAY_END + 3;

  // Configuration registers.
  logic               use_shared;
  logic signed [15:0] shared_rate;
  logic signed [31:0] shared_capacity;

  always_ff @(posedge clk) begin
    if (rst) begin
      use_shared      <= 1'b0;
      shared_rate     <= 16'sd0;
      shared_capacity <= SHARED_CAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_USE_SHARED:      use_shared      <= cfg_data[0];
        REG_SHARED_RATE:     shared_rate     <= cfg_data[15:0];
        REG_SHARED_CAPACITY: shared_capacity <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline advance and the valid bits that travel with the data.
  logic [NST-1:0] vld;
  logic           adv;

  assign adv          = !(vld[NST-1] && result_stall);
  assign item_stall   = !adv;
  assign result_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], item_valid};
    end
  end

  // Input stage: pick rate and capacity, flag the forced-zero cases and
  // check whether the quotient runs past its clamp.
  logic signed [15:0] sel_r;
  logic signed [31:0] sel_k;
  div_t               d [0:DIV_BITS];

  assign sel_r = use_shared ? shared_rate : item.rate;
  assign sel_k = use_shared ? shared_capacity : item.capacity;

  always_ff @(posedge clk) begin
    if (adv) begin
      d[0].n    <= item.abundance;
      d[0].r    <= sel_r;
      d[0].k    <= sel_k;
      d[0].rem  <= {19'd0, item.abundance[31:19]};
      d[0].q    <= '0;
      d[0].ovf  <= {19'd0, item.abundance[31:19]} >= $unsigned(sel_k);
      d[0].neg  <= sel_r[15];
      d[0].zero <= sel_k[31] || (sel_k == 32'sd0) ||
                   (!sel_r[15] && (item.abundance == 32'd0));
    end
  end

  // Restoring divider: one quotient bit of N*2^30/K per stage.
  for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
    localparam int B = DIV_BITS - 1 - j;
    logic        dbit;
    logic [31:0] sh;
    div_t        dn;

    if (B >= 30) begin : g_bit
      assign dbit = d[j].n[B-30];
    end else begin : g_nobit
      assign dbit = 1'b0;
    end

    always_comb begin
      dn = d[j];
      sh = {d[j].rem[30:0], dbit};
      if (sh >= d[j].k) begin
        dn.rem  = sh - d[j].k;
        dn.q[B] = 1'b1;
      end else begin
        dn.rem = sh;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d[j+1] <= dn;
      end
    end
  end

  // Exponent, first stage: clamp the ratio and take its distance from one.
  logic [48:0]        ratio;
  logic [31:0]        x0_n;
  logic signed [15:0] x0_r;
  logic               x0_neg;
  logic               x0_zero;
  logic               x0_ge;
  logic [48:0]        x0_diff;

  assign ratio = (d[DIV_BITS].ovf || (d[DIV_BITS].q > RATIO_CAP)) ?
                 RATIO_CAP : d[DIV_BITS].q;

  always_ff @(posedge clk) begin
    if (adv) begin
      x0_n    <= d[DIV_BITS].n;
      x0_r    <= d[DIV_BITS].r;
      x0_neg  <= d[DIV_BITS].neg;
      x0_zero <= d[DIV_BITS].zero;
      x0_ge   <= ratio <= 49'(ONE_Q30);
      x0_diff <= (ratio <= 49'(ONE_Q30)) ? 49'(ONE_Q30) - ratio :
                                           ratio - 49'(ONE_Q30);
    end
  end

  // Exponent, second stage: rate times distance as two partial products.
  logic [31:0]        x1_n;
  logic signed [15:0] x1_r;
  logic               x1_neg;
  logic               x1_zero;
  logic               x1_ge;
  logic [38:0]        x1_lo;
  logic [39:0]        x1_hi;

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_n    <= x0_n;
      x1_r    <= x0_r;
      x1_neg  <= x0_neg;
      x1_zero <= x0_zero;
      x1_ge   <= x0_ge;
      x1_lo   <= 39'(x0_r[14:0]) * 39'(x0_diff[23:0]);
      x1_hi   <= 40'(x0_r[14:0]) * 40'(x0_diff[48:24]);
    end
  end

  // Exponent, third stage: form x + 64*ln2 and catch exponents below -32.
  logic [63:0]        mag;
  logic [51:0]        m;
  logic               tiny;
  logic signed [38:0] xneg;
  logic [36:0]        xo;
  kq_t                kq [0:KQ_BITS];

  always_comb begin
    mag  = {x1_hi, 24'd0} + 64'(x1_lo);
    m    = mag[63:12];
    tiny = !x1_neg && !x1_ge && (m > TINY_MAG);
    xneg = 39'(LN2_X64) + 39'($signed({x1_r, 18'd0}));
    if (x1_neg) begin
      xo = xneg[36:0];
    end else if (x1_ge) begin
      xo = LN2_X64 + m[36:0];
    end else begin
      xo = LN2_X64 - m[36:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kq[0].n    <= x1_n;
      kq[0].rem  <= xo;
      kq[0].kq   <= '0;
      kq[0].zero <= x1_zero || tiny;
    end
  end

  // Split by ln 2: one bit of the integer part per stage.
  for (genvar j = 0; j < KQ_BITS; j++) begin : g_kq
    localparam int B = KQ_BITS - 1 - j;
    localparam logic [36:0] LIM = LN2_Q30 << B;
    kq_t kn;

    always_comb begin
      kn = kq[j];
      if (kq[j].rem >= LIM) begin
        kn.rem   = kq[j].rem - LIM;
        kn.kq[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        kq[j+1] <= kn;
      end
    end
  end

  // Taylor series: per term a multiply, a reciprocal multiply and a fix-up.
  tay_t t0;
  tay_t tr [1:TAY_STEPS];

  always_comb begin
    t0      = '0;
    t0.n    = kq[KQ_BITS].n;
    t0.kq   = kq[KQ_BITS].kq;
    t0.rr   = kq[KQ_BITS].rem[29:0];
    t0.term = ONE_Q30;
    t0.sum  = 32'(ONE_Q30);
    t0.zero = kq[KQ_BITS].zero;
  end

  for (genvar s = 0; s < TAY_STEPS; s++) begin : g_tay
    localparam int I  = s / 3 + 1;
    localparam int PH = s % 3;
    tay_t        src;
    tay_t        tn;
    logic [30:0] trem;

    if (s == 0) begin : g_first
      assign src = t0;
    end else begin : g_rest
      assign src = tr[s];
    end

    always_comb begin
      tn   = src;
      trem = src.p - src.q0 * 31'(I);
      case (PH)
        0: tn.p = 31'((64'(src.term) * 64'(src.rr)) >> 30);
        1: tn.q0 = 31'((64'(src.p) * 64'(RECIP[I])) >> 32);
        default: begin
          tn.term = (trem >= 31'(I)) ? src.q0 + 31'd1 : src.q0;
          tn.sum  = src.sum + 32'((trem >= 31'(I)) ? src.q0 + 31'd1 : src.q0);
        end
      endcase
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        tr[s+1] <= tn;
      end
    end
  end

  // Product of abundance and exp(f).
  logic [63:0]        pr_prod;
  logic [KQ_BITS-1:0] pr_kq;
  logic               pr_zero;

  always_ff @(posedge clk) begin
    if (adv) begin
      pr_prod <= 64'(tr[TAY_STEPS].n) * 64'(tr[TAY_STEPS].sum);
      pr_kq   <= tr[TAY_STEPS].kq;
      pr_zero <= tr[TAY_STEPS].zero;
    end
  end

  // Scale by 2^k, saturate and register the result.
  logic [KQ_BITS-1:0] shift;
  logic [63:0]        res;
  logic               sat;

  always_comb begin
    shift = KQ_BITS'(94) - pr_kq;
    res   = (shift >= KQ_BITS'(64)) ? 64'd0 : pr_prod >> shift[5:0];
    sat   = |res[63:32];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.next_abundance <= pr_zero ? 32'd0 : (sat ? 32'hFFFF_FFFF : res[31:0]);
      result.saturated      <= !pr_zero && sat;
    end
  end

  // Checks on the datapath.
  `RPS_ASSERT_NOW(a_sat_clamps, clk, rst, result_valid && result.saturated, result.next_abundance == 32'hFFFF_FFFF, "saturated result is not clamped")
  `RPS_ASSERT_NOW(a_kq_range, clk, rst, vld[ST_KQ_LAST] && !kq[KQ_BITS].zero, kq[KQ_BITS].kq <= KQ_BITS'(75) && kq[KQ_BITS].rem < LN2_Q30, "ln2 split out of range")
  `RPS_ASSERT_NOW(a_sum_range, clk, rst, vld[ST_TAY_END] && !tr[TAY_STEPS].zero, tr[TAY_STEPS].sum >= 32'(ONE_Q30) && tr[TAY_STEPS].sum < 32'h8000_0000, "exp(f) outside [1, 2)")
  `RPS_ASSERT_NEXT(a_pass_on, clk, rst, adv && vld[ST_KQ0], vld[ST_KQ0+1], "pipeline dropped an entry")

endmodule

/* dv/tb_ricker_population_step.sv */
// Ricker step testbench: directed table, shared-register phases, random cells,
// checked field by field against a fixed-point predictor. Depends on rps_pkg.
`timescale 1ns / 1ps

module tb_ricker_population_step;
  import rps_pkg::*;

  localparam int LATENCY = 98;
  localparam longint LIMIT = 400000;
  localparam longint LN2 = 744261118;
  localparam longint ONE = 64'd1073741824;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_USE_SHARED;
  logic [31:0] cfg_data = '0;

  // Predictor copy of the configuration registers.
  logic m_use_shared;
  logic signed [15:0] m_rate;
  logic signed [31:0] m_cap;

  result_t next_gen_q[$];
  int errors = 0;
  longint cycles = 0;
  bit hold_long = 1'b0;

  ricker_population_step dut (.*);

  always #1 clk = ~clk;

  // Cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Computes floor(n * exp(x)) with x in Q.30, saturating at 32 bits.
  function automatic result_t scale_exp(logic [31:0] n, longint x);
    result_t o;
    logic [63:0] xo, kq, rr, sum, term, prod, res;
    o = '0;
    if (x < -(64'sd32 * ONE)) return o;
    xo = x + 64 * LN2;
    kq = xo / LN2;
    rr = xo - kq * LN2;
    sum = ONE;
    term = ONE;
    for (int i = 1; i <= 12; i++) begin
      term = ((term * rr) >> 30) / i;
      sum += term;
    end
    prod = 64'(n) * sum;
    if (94 - kq >= 64) return o;
    res = prod >> (94 - kq);
    if (res > 64'hFFFF_FFFF) begin
      o.next_abundance = '1;
      o.saturated = 1'b1;
    end else begin
      o.next_abundance = res[31:0];
    end
    return o;
  endfunction

  // Next abundance of one cell under the current register settings.
  function automatic result_t ricker_next(item_t it);
    longint r, k, x;
    logic [63:0] ratio;
    result_t o;
    r = longint'(m_use_shared ? m_rate : it.rate);
    k = longint'(m_use_shared ? m_cap : it.capacity);
    o = '0;
    if (k <= 0) return o;
    if (r < 0) return scale_exp(it.abundance, r * 262144);
    if (it.abundance == 0) return o;
    ratio = (64'(it.abundance) << 30) / 64'(k);
    if (ratio > 64'h1_0000_0000_0000) ratio = 64'h1_0000_0000_0000;
    if (ratio <= ONE) x = (64'(r) * (ONE - ratio)) >> 12;
    else x = -longint'((64'(r) * (ratio - ONE)) >> 12);
    return scale_exp(it.abundance, x);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Result checker.
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (next_gen_q.size() == 0) begin
        report_mismatch("unexpected result", result.next_abundance, 32'd0);
      end else begin
        want = next_gen_q.pop_front();
        if (result.next_abundance !== want.next_abundance)
          report_mismatch("next_abundance", result.next_abundance, want.next_abundance);
        if (result.saturated !== want.saturated)
          report_mismatch("saturated", 32'(result.saturated), 32'(want.saturated));
      end
    end
  end

  // Receiver stalls on its own pattern, with a long hold-off each time one is requested.
  initial begin
    int mode;
    forever begin
      @(negedge clk);
      if (hold_long) begin
        result_stall <= 1'b1;
        repeat (300) @(negedge clk);
        hold_long = 1'b0;
      end
      mode = int'((cycles / 500) % 3);
      if (mode == 0) result_stall <= 1'b0;
      else if (mode == 1) result_stall <= ($urandom_range(0, 3) == 0);
      else result_stall <= ($urandom_range(0, 1) == 0);
    end
  end

  // Offers one request and holds it until accepted; predicts on acceptance.
  task automatic send_cell(item_t it);
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    next_gen_q.push_back(ricker_next(it));
    @(negedge clk);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (next_gen_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_USE_SHARED: m_use_shared = val[0];
      REG_SHARED_RATE: m_rate = val[15:0];
      default: m_cap = val;
    endcase
  endtask

  function automatic item_t rand_cell();
    item_t it;
    it.abundance = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h00C8_0000);
    it.rate = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16'h2800));
    case ($urandom_range(0, 5))
      0: it.capacity = $urandom;
      1: it.capacity = -$signed(32'($urandom_range(0, 1000)));
      default: it.capacity = $urandom_range(1, 32'h0100_0000);
    endcase
    return it;
  endfunction

  // Directed rows: abundance, rate, capacity, whether a result is typed in.
  typedef struct {
    logic [31:0] n;
    logic [15:0] r;
    logic [31:0] k;
    bit known;
    result_t want;
  } row_t;

  row_t rows[] = '{
    '{32'h0001_0000, 16'h1000, 32'h0000_0000, 1, '{32'h0, 1'b0}},
    '{32'hFFFF_FFFF, 16'h7FFF, 32'h8000_0000, 1, '{32'h0, 1'b0}},
    '{32'h0000_0000, 16'h7FFF, 32'h0064_0000, 1, '{32'h0, 1'b0}},
    '{32'h0000_0000, 16'h8000, 32'h7FFF_FFFF, 1, '{32'h0, 1'b0}},
    '{32'h0010_0000, 16'h0000, 32'h0064_0000, 1, '{32'h0010_0000, 1'b0}},
    '{32'h0000_0001, 16'h8000, 32'h7FFF_FFFF, 1, '{32'h0, 1'b0}},
    '{32'h4000_0000, 16'h7FFF, 32'h7FFF_FFFF, 1, '{32'hFFFF_FFFF, 1'b1}},
    '{32'h0000_0001, 16'h7FFF, 32'h7FFF_FFFF, 0, '{32'h0, 1'b0}},
    '{32'hFFFF_FFFF, 16'hFFFF, 32'h0000_0001, 0, '{32'h0, 1'b0}},
    '{32'hFFFF_FFFF, 16'h8000, 32'h0000_0001, 0, '{32'h0, 1'b0}},
    '{32'hFFFF_FFFF, 16'h7FFF, 32'h0000_0001, 0, '{32'h0, 1'b0}},
    '{32'hFFFF_FFFF, 16'h0001, 32'h0000_0001, 0, '{32'h0, 1'b0}},
    '{32'h0032_0000, 16'h1800, 32'h0064_0000, 0, '{32'h0, 1'b0}},
    '{32'h0064_0000, 16'h2000, 32'h0064_0000, 0, '{32'h0, 1'b0}},
    '{32'h00C8_0000, 16'h4000, 32'h0064_0000, 0, '{32'h0, 1'b0}},
    '{32'h8000_0000, 16'hF000, 32'h0064_0000, 0, '{32'h0, 1'b0}},
    '{32'h0001_0000, 16'h7FFF, 32'h0A00_0000, 0, '{32'h0, 1'b0}},
    '{32'h5555_5555, 16'h5555, 32'h2AAA_AAAA, 0, '{32'h0, 1'b0}},
    '{32'hAAAA_AAAA, 16'hAAAA, 32'h5555_5555, 0, '{32'h0, 1'b0}}
  };

  // Main stimulus sequence.
  initial begin
    item_t it;
    result_t p;
    m_use_shared = 1'b0;
    m_rate = '0;
    m_cap = SHARED_CAP_RESET;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table.
    foreach (rows[i]) begin
      it = '{rows[i].n, rows[i].r, rows[i].k};
      p = ricker_next(it);
      if (rows[i].known && p !== rows[i].want)
        report_mismatch("table row", p.next_abundance, rows[i].want.next_abundance);
      send_cell(it);
    end
    drain();

    // Shared-register phases, the extremes among them.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(REG_USE_SHARED, 1); end
        1: begin write_reg(REG_SHARED_RATE, 32'h7FFF); write_reg(REG_SHARED_CAPACITY, 32'h7FFF_FFFF); end
        2: begin write_reg(REG_SHARED_RATE, 32'h8000); write_reg(REG_SHARED_CAPACITY, 32'h8000_0000); end
        3: begin write_reg(REG_SHARED_RATE, 32'h1800); write_reg(REG_SHARED_CAPACITY, 32'h0064_0000); end
        default: begin write_reg(REG_SHARED_RATE, 32'hF800); write_reg(REG_SHARED_CAPACITY, 32'h0000_0001); end
      endcase
      repeat (20) send_cell(rand_cell());
      drain();
    end
    write_reg(REG_USE_SHARED, 0);

    // Random cells in bursts, with long receiver hold-offs and drains between some bursts.
    for (int sent = 0; sent < 300;) begin
      int burst;
      burst = $urandom_range(1, 30);
      if (sent > 100 && sent < 140) hold_long = 1'b1;
      for (int b = 0; b < burst; b++) begin
        send_cell(rand_cell());
        sent++;
      end
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      if (sent > 200 && sent < 240) drain();
    end
    drain();

    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

/* ricker_population_step.f */
+incdir+sv
sv/rps_pkg.sv
sv/ricker_population_step.sv
dv/tb_ricker_population_step.sv
